>>> hdl/pip_pkg.sv
// Package for the point-in-polygon test unit.
// Holds the sequencer state type, item and register codes, and datapath widths.
// No dependencies.
package pip_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_FETCH,
    ST_MUL,
    ST_EVAL,
    ST_DONE
  } state_t;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] CFG_SIDE_COUNT = 2'd0;
  localparam logic [1:0] CFG_CENTER_X   = 2'd1;
  localparam logic [1:0] CFG_CENTER_Y   = 2'd2;

  localparam int MIN_SIDES = 3;

  // Edge operands are 34-bit signed; the multiplier takes 17-bit slices of one factor.
  localparam int OPW       = 34;
  localparam int SLICEW    = 17;
  localparam int PRODW     = OPW + SLICEW + 1;
  localparam int ACCW      = 70;
  localparam int MUL_STEPS = 4;

endpackage

>>> hdl/point_in_polygon_test_unit.sv
// Point-in-polygon test unit: vertex memory, edge sequencer and shared multiplier.
// Depends on pip_pkg for the state type, codes and widths.
//
// A vertex write (func 0) gives no result. A query (func 1) raises its result once
// every edge of the polygon set by the side count in use is done, and the next item may
// then transfer. Each edge takes its far vertex from the single read port of the
// vertex memory, makes four passes through the one shared 34x18 multiplier and then
// drains its product register into the accumulator, and evaluates the crossing; state
// ST_FIRST loads the first vertex and state ST_DONE hands the result to the output.
// The unit accepts no item while a query is in progress. A finished result sits in an
// output register, so writes and a new query may transfer while it waits.
module point_in_polygon_test_unit #(
  parameter int MAX_SIDES = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [3:0]         in_vertex_index,
  input  logic signed [31:0] in_vert_x,
  input  logic signed [31:0] in_vert_y,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_inside_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import pip_pkg::*;

  localparam int AW = (MAX_SIDES > 1) ? $clog2(MAX_SIDES) : 1;
  localparam int NW = $clog2(MAX_SIDES + 1);

  state_t state_r, state_nxt;

  logic [3:0]         side_count_r;
  logic signed [31:0] cx_r, cy_r;

  logic signed [31:0] mem_x [MAX_SIDES];
  logic signed [31:0] mem_y [MAX_SIDES];
  logic signed [31:0] rd_x_r, rd_y_r;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;

  logic [NW-1:0]      n_r, n_cl;
  logic [NW-1:0]      cnt_r;
  logic [NW:0]        j2;
  logic [2:0]         step_r;
  logic               par_r;

  logic signed [31:0] px_r, py_r;
  logic signed [32:0] a_x_r, a_y_r, b_x_r, b_y_r;
  logic signed [32:0] b_x, b_y;
  logic signed [OPW-1:0] dx, dy, pa, pb, pya;
  logic signed [OPW-1:0] dx_r, dy_r, pa_r, pya_r;
  logic               hit, hit_r;

  logic signed [OPW-1:0]    mul_a;
  logic signed [SLICEW:0]   mul_b;
  logic signed [PRODW-1:0]  prod_r;
  logic                     sub_r, shl_r;
  logic signed [ACCW-1:0]   term, acc_base, acc_r;

  logic dx_pos, crossed, last_edge, out_free;
  logic out_valid_r, out_inside_res_r;

  assign in_ready       = (state_r == ST_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_res_r;
  assign out_free       = !out_valid_r || out_ready;

  always_comb begin
    if (side_count_r < 4'(MIN_SIDES)) begin
      n_cl = NW'(MIN_SIDES);
    end else if (int'(side_count_r) > MAX_SIDES) begin
      n_cl = NW'(MAX_SIDES);
    end else begin
      n_cl = NW'(side_count_r);
    end
  end

  assign mem_we = in_valid && in_ready && (in_func == FUNC_WRITE) &&
                  (int'(in_vertex_index) < MAX_SIDES);

  assign j2        = (NW + 1)'(cnt_r) + (NW + 1)'(2);
  assign last_edge = ((NW + 1)'(cnt_r) + (NW + 1)'(1)) == (NW + 1)'(n_r);

  always_comb begin
    case (state_r)
      ST_FIRST: rd_addr = AW'(1);
      ST_EVAL:  rd_addr = (j2 == (NW + 1)'(n_r)) ? '0 : AW'(j2);
      default:  rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[AW'(in_vertex_index)] <= in_vert_x;
      mem_y[AW'(in_vertex_index)] <= in_vert_y;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  assign b_x = 33'(rd_x_r) + 33'(cx_r);
  assign b_y = 33'(rd_y_r) + 33'(cy_r);
  assign dx  = OPW'(b_x) - OPW'(a_x_r);
  assign dy  = OPW'(b_y) - OPW'(a_y_r);
  assign pa  = OPW'(px_r) - OPW'(a_x_r);
  assign pb  = OPW'(px_r) - OPW'(b_x);
  assign pya = OPW'(py_r) - OPW'(a_y_r);
  assign hit = (!dx[OPW-1] && dx != '0) ?
               ((!pa[OPW-1] && pa != '0) && (pb[OPW-1] || pb == '0)) :
               ((!pb[OPW-1] && pb != '0) && (pa[OPW-1] || pa == '0));

  always_comb begin
    case (step_r[1:0])
      2'd0: begin
        mul_a = pya_r;
        mul_b = {1'b0, dx_r[SLICEW-1:0]};
      end
      2'd1: begin
        mul_a = pya_r;
        mul_b = {dx_r[OPW-1], dx_r[OPW-1:SLICEW]};
      end
      2'd2: begin
        mul_a = pa_r;
        mul_b = {1'b0, dy_r[SLICEW-1:0]};
      end
      default: begin
        mul_a = pa_r;
        mul_b = {dy_r[OPW-1], dy_r[OPW-1:SLICEW]};
      end
    endcase
  end

  assign term     = shl_r ? (ACCW'(prod_r) <<< SLICEW) : ACCW'(prod_r);
  assign acc_base = (step_r == 3'd1) ? '0 : acc_r;

  assign dx_pos  = !dx_r[OPW-1] && (dx_r != '0);
  assign crossed = hit_r && (dx_pos ? (acc_r[ACCW-1] || acc_r == '0) : !acc_r[ACCW-1]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_func == FUNC_QUERY) begin
          state_nxt = ST_FIRST;
        end
      end
      ST_FIRST: state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_MUL;
      ST_MUL: begin
        if (step_r == 3'(MUL_STEPS)) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL:  state_nxt = last_edge ? ST_DONE : ST_FETCH;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      side_count_r <= 4'(MIN_SIDES);
      cx_r         <= '0;
      cy_r         <= '0;
      out_valid_r  <= 1'b0;
      step_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SIDE_COUNT: side_count_r <= cfg_data[3:0];
          CFG_CENTER_X:   cx_r <= cfg_data;
          CFG_CENTER_Y:   cy_r <= cfg_data;
          default:        ;
        endcase
      end
      if (state_r == ST_MUL) begin
        step_r <= (step_r == 3'(MUL_STEPS)) ? '0 : step_r + 3'd1;
      end else begin
        step_r <= '0;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        px_r  <= in_point_x;
        py_r  <= in_point_y;
        n_r   <= n_cl;
        cnt_r <= '0;
        par_r <= 1'b0;
      end
      ST_FIRST: begin
        a_x_r <= b_x;
        a_y_r <= b_y;
      end
      ST_FETCH: begin
        b_x_r <= b_x;
        b_y_r <= b_y;
        dx_r  <= dx;
        dy_r  <= dy;
        pa_r  <= pa;
        pya_r <= pya;
        hit_r <= hit;
      end
      ST_MUL: begin
        if (step_r < 3'(MUL_STEPS)) begin
          prod_r <= mul_a * mul_b;
          sub_r  <= step_r[1];
          shl_r  <= step_r[0];
        end
        if (step_r != 3'd0) begin
          acc_r <= sub_r ? (acc_base - term) : (acc_base + term);
        end
      end
      ST_EVAL: begin
        par_r <= par_r ^ crossed;
        a_x_r <= b_x_r;
        a_y_r <= b_y_r;
        cnt_r <= cnt_r + NW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_inside_res_r <= par_r;
        end
      end
      default: ;
    endcase
  end

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |-> step_r <= 3'(MUL_STEPS))
    else $error("multiplier step counter overran");

  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH || state_r == ST_EVAL) |-> cnt_r < n_r)
    else $error("edge counter beyond side count");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside the done state");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func == FUNC_QUERY) |=> !in_ready)
    else $error("input taken while a query is in progress");

endmodule

>>> tb/sv/pip_tb_pkg.sv
// Scoreboard for the point-in-polygon test unit bench: predicts the inside flag of each query.
// Depends on pip_pkg for the item codes, register codes and the minimum side count.
package pip_tb_pkg;
  import pip_pkg::*;

  localparam int POLY_SLOTS = 10;
  localparam logic [1:0] CFG_RESERVED = 2'd3;

  class polygon_scoreboard;
    int vx_mem[POLY_SLOTS];
    int vy_mem[POLY_SLOTS];
    logic [3:0] sides_cfg;
    int cx_cfg;
    int cy_cfg;
    bit expected_in_poly[$];
    int unsigned mismatches;
    int unsigned writes_seen;
    int unsigned queries_seen;
    int unsigned cfg_writes;
    int unsigned in_results;
    int unsigned out_results;

    function new();
      foreach (vx_mem[i]) begin
        vx_mem[i] = 0;
        vy_mem[i] = 0;
      end
      sides_cfg = 4'd3;
      cx_cfg = 0;
      cy_cfg = 0;
    endfunction

    function int unsigned sides_used();
      if (sides_cfg < MIN_SIDES) return MIN_SIDES;
      if (sides_cfg > POLY_SLOTS) return POLY_SLOTS;
      return sides_cfg;
    endfunction

    // The edge line is compared at the point's x by cross-multiplying with dx, so the
    // sense of the comparison follows the sign of dx.
    function bit crosses_edge(int unsigned a, int unsigned b, longint px, longint py);
      longint ax, ay, bx, by;
      logic signed [127:0] dx, dy, rise, run;
      ax = longint'(vx_mem[a]) + longint'(cx_cfg);
      ay = longint'(vy_mem[a]) + longint'(cy_cfg);
      bx = longint'(vx_mem[b]) + longint'(cx_cfg);
      by = longint'(vy_mem[b]) + longint'(cy_cfg);
      if (px <= ((ax < bx) ? ax : bx) || px > ((ax < bx) ? bx : ax)) return 1'b0;
      dx = bx - ax;
      dy = by - ay;
      rise = py - ay;
      run = px - ax;
      if (dx > 0) return (rise * dx) <= (dy * run);
      return (rise * dx) >= (dy * run);
    endfunction

    function bit point_in_poly(int px, int py);
      int unsigned n;
      bit parity;
      n = sides_used();
      parity = 1'b0;
      for (int unsigned i = 0; i < n; i++) begin
        parity ^= crosses_edge(i, (i + 1 == n) ? 0 : i + 1, px, py);
      end
      return parity;
    endfunction

    function void note_item(logic func, logic [3:0] idx, int vx, int vy, int px, int py);
      if (func == FUNC_WRITE) begin
        writes_seen++;
        if (idx < POLY_SLOTS) begin
          vx_mem[idx] = vx;
          vy_mem[idx] = vy;
        end
      end else begin
        queries_seen++;
        expected_in_poly.push_back(point_in_poly(px, py));
      end
    endfunction

    function void note_config(logic [1:0] idx, logic [31:0] data);
      cfg_writes++;
      case (idx)
        CFG_SIDE_COUNT: sides_cfg = data[3:0];
        CFG_CENTER_X: cx_cfg = data;
        CFG_CENTER_Y: cy_cfg = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_in_poly.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_result(logic got);
      bit want;
      if (expected_in_poly.size() == 0) begin
        report($sformatf("inside_res %b arrived with no query pending", got));
        return;
      end
      want = expected_in_poly.pop_front();
      if (want) begin
        in_results++;
      end else begin
        out_results++;
      end
      if (got !== want) begin
        report($sformatf("inside_res is %b, expected %b", got, want));
      end
    endtask
  endclass

endpackage

>>> tb/sv/tb_point_in_polygon_test_unit.sv
// Testbench top for point_in_polygon_test_unit: random polygons, queries and register settings.
// Depends on pip_pkg, pip_tb_pkg and the unit's RTL.
module tb_point_in_polygon_test_unit;
  import pip_pkg::*;
  import pip_tb_pkg::*;

  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 100;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 100;
  localparam int LONG_HOLD = 250;
  localparam int STALL_LIMIT = 3000;
  localparam int Q_ONE = 32'sh0001_0000;
  localparam int COORD_MIN = 32'sh8000_0000;
  localparam int COORD_MAX = 32'sh7FFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = FUNC_WRITE;
  logic [3:0] in_vertex_index = 4'd0;
  logic signed [31:0] in_vert_x = '0;
  logic signed [31:0] in_vert_y = '0;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_inside_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_SIDE_COUNT;
  logic [31:0] cfg_data = '0;

  bit in_no_gaps = 1'b0;
  bit out_no_gaps = 1'b0;
  int unsigned results_seen = 0;
  int unsigned stall_cycles = 0;
  int unsigned side_plan[PHASES] = '{10, 3, 0, 15, 7, 2, 11, 4, 9, 1, 13, 6};
  int unsigned scale_plan[PHASES] = '{32, 12, 20, 4, 32, 16, 8, 24, 32, 6, 28, 18};

  polygon_scoreboard sb = new();

  point_in_polygon_test_unit #(.MAX_SIDES(POLY_SLOTS)) dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side. Two long hold-offs let the unit fill up and stall its input.
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_result(out_inside_res);
        results_seen++;
        hold = out_no_gaps ? 0 : $urandom_range(0, 15);
        if (results_seen == 100 || results_seen == 600) hold = LONG_HOLD;
      end else if (hold != 0) begin
        hold--;
      end
      out_ready <= (hold == 0);
    end
  end

  function automatic int rand_coord(int unsigned bits);
    int v;
    v = $urandom;
    return v >>> (32 - bits);
  endfunction

  function automatic longint pick_between(longint lo, longint hi);
    longint unsigned w;
    w = hi - lo + 1;
    return lo + longint'({$urandom, $urandom} % w);
  endfunction

  function automatic logic [31:0] center_value(int unsigned sel);
    case (sel % 5)
      0: return 32'd0;
      1: return COORD_MAX;
      2: return COORD_MIN;
      3: return rand_coord(20);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic func, logic [3:0] idx, int vx, int vy, int px, int py);
    int unsigned gap;
    gap = in_no_gaps ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_vertex_index <= idx;
    in_vert_x <= vx;
    in_vert_y <= vy;
    in_point_x <= px;
    in_point_y <= py;
    do @(posedge clk); while (!in_ready);
    sb.note_item(func, idx, vx, vy, px, py);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    send_item(FUNC_WRITE, 4'd0, 0, 0, COORD_MAX, COORD_MIN);
    send_item(FUNC_WRITE, 4'd1, 8 * Q_ONE, 0, COORD_MIN, COORD_MAX);
    send_item(FUNC_WRITE, 4'd2, 0, 8 * Q_ONE, -1, 0);
    send_item(FUNC_WRITE, 4'd3, COORD_MIN, COORD_MIN, 0, -1);
    send_item(FUNC_WRITE, 4'd4, COORD_MAX, COORD_MAX, 0, 0);
    send_item(FUNC_WRITE, 4'd5, COORD_MAX, COORD_MIN, 0, 0);
    send_item(FUNC_WRITE, 4'd6, COORD_MIN, COORD_MAX, 0, 0);
    send_item(FUNC_WRITE, 4'd7, 0, COORD_MAX, 0, 0);
    send_item(FUNC_WRITE, 4'd8, COORD_MAX, 0, 0, 0);
    send_item(FUNC_WRITE, 4'd9, -1, -1, 0, 0);
    send_item(FUNC_WRITE, 4'd10, COORD_MAX, COORD_MAX, 0, 0);
    send_item(FUNC_WRITE, 4'd15, COORD_MIN, COORD_MIN, -1, -1);
    send_item(FUNC_QUERY, 4'd15, -1, -1, Q_ONE, Q_ONE);
    send_item(FUNC_QUERY, 4'd0, 0, 0, 9 * Q_ONE, Q_ONE);
    send_item(FUNC_QUERY, 4'd0, 0, 0, 0, 0);
    send_item(FUNC_QUERY, 4'd0, 0, 0, 8 * Q_ONE, 0);
    send_item(FUNC_QUERY, 4'd0, 0, 0, 4 * Q_ONE, 4 * Q_ONE);
    send_item(FUNC_QUERY, 4'd0, 0, 0, 0, Q_ONE);
    send_item(FUNC_QUERY, 4'd0, 0, 0, COORD_MIN, COORD_MIN);
    send_item(FUNC_QUERY, 4'd0, 0, 0, COORD_MAX, COORD_MAX);
    send_item(FUNC_QUERY, 4'd0, 0, 0, COORD_MIN, COORD_MAX);
    send_item(FUNC_QUERY, 4'd0, 0, 0, COORD_MAX, COORD_MIN);
  endtask

  task automatic load_polygon(int unsigned bits);
    int x, y;
    x = rand_coord(bits);
    y = rand_coord(bits);
    for (int k = 0; k < POLY_SLOTS; k++) begin
      case ($urandom_range(0, 5))
        0: y = rand_coord(bits);
        1: x = rand_coord(bits);
        default: begin
          x = rand_coord(bits);
          y = rand_coord(bits);
        end
      endcase
      send_item(FUNC_WRITE, 4'(k), x, y, $urandom, $urandom);
    end
  endtask

  // Most points fall inside the bounding box of the vertices in use; some sit exactly on a
  // vertex, on a vertex column or at an edge midpoint, and some land anywhere.
  task automatic send_query();
    longint cx, cy, lo_x, hi_x, lo_y, hi_y, vx_i, vy_i, px, py;
    int unsigned n, k, m;
    cx = sb.cx_cfg;
    cy = sb.cy_cfg;
    n = sb.sides_used();
    lo_x = longint'(sb.vx_mem[0]) + cx;
    hi_x = lo_x;
    lo_y = longint'(sb.vy_mem[0]) + cy;
    hi_y = lo_y;
    for (int i = 1; i < int'(n); i++) begin
      vx_i = longint'(sb.vx_mem[i]) + cx;
      vy_i = longint'(sb.vy_mem[i]) + cy;
      if (vx_i < lo_x) lo_x = vx_i;
      if (vx_i > hi_x) hi_x = vx_i;
      if (vy_i < lo_y) lo_y = vy_i;
      if (vy_i > hi_y) hi_y = vy_i;
    end
    k = $urandom_range(0, n - 1);
    m = (k + 1 == n) ? 0 : k + 1;
    case ($urandom_range(0, 9))
      0: begin
        px = rand_coord(32);
        py = rand_coord(32);
      end
      1: begin
        px = longint'(sb.vx_mem[k]) + cx;
        py = longint'(sb.vy_mem[k]) + cy;
      end
      2: begin
        px = longint'(sb.vx_mem[k]) + cx;
        py = pick_between(lo_y, hi_y);
      end
      3: begin
        px = (longint'(sb.vx_mem[k]) + longint'(sb.vx_mem[m])) / 2 + cx;
        py = (longint'(sb.vy_mem[k]) + longint'(sb.vy_mem[m])) / 2 + cy;
      end
      default: begin
        px = pick_between(lo_x, hi_x);
        py = pick_between(lo_y, hi_y);
      end
    endcase
    send_item(FUNC_QUERY, 4'($urandom), $urandom, $urandom, int'(px), int'(py));
  endtask

  task automatic send_random_item(int unsigned bits);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      send_item(FUNC_WRITE, 4'($urandom_range(0, POLY_SLOTS - 1)), rand_coord(bits),
                rand_coord(bits), $urandom, $urandom);
    end else if (roll < 16) begin
      send_item(FUNC_WRITE, 4'($urandom_range(POLY_SLOTS, 15)), $urandom, $urandom,
                $urandom, $urandom);
    end else begin
      send_query();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_reg(CFG_SIDE_COUNT, {28'($urandom), 4'(side_plan[ph])});
      write_reg(CFG_CENTER_X, center_value(ph));
      write_reg(CFG_CENTER_Y, center_value(ph + 2));
      write_reg(CFG_RESERVED, $urandom);
      cfg_valid <= 1'b0;
      in_no_gaps = (ph % 4 == 3);
      out_no_gaps = (ph % 3 == 1);
      if (ph != 0) load_polygon(scale_plan[ph]);
      repeat (PHASE_ITEMS) send_random_item(scale_plan[ph]);
    end
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d vertex writes and %0d queries under %0d register settings (%0d writes).",
             sb.writes_seen, sb.queries_seen, PHASES + 1, sb.cfg_writes);
    $display("Checked %0d results: %0d inside, %0d outside.",
             results_seen, sb.in_results, sb.out_results);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
